FILE: rtl/rotation_matrix_to_quaternion_core_macros.svh
// Assertion macros for the rotation matrix to quaternion core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// Property that holds on every clock outside reset.
`define RMQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Implication; the consequent may carry a fixed delay.
`define RMQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

`endif

FILE: rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion core.
// No dependencies.
`default_nettype none

package rmq_pkg;

  typedef struct packed {
    logic signed [31:0] rot_m00;
    logic signed [31:0] rot_m01;
    logic signed [31:0] rot_m02;
    logic signed [31:0] rot_m10;
    logic signed [31:0] rot_m11;
    logic signed [31:0] rot_m12;
    logic signed [31:0] rot_m20;
    logic signed [31:0] rot_m21;
    logic signed [31:0] rot_m22;
  } rmq_mat_t;

  typedef struct packed {
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic               invalid;
  } rmq_quat_t;

  // Normalized magnitudes and signs, lanes x, y, z, w at 0..3.
  typedef struct packed {
    logic [3:0][30:0] mag;
    logic [3:0]       neg;
    logic             invalid;
  } rmq_side_t;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  localparam int FRONT_STAGES = 7;
  localparam int SQ_STAGES    = 32;
  localparam int DIV_STEPS    = 31;
  // setup register, quotient steps, output register
  localparam int LATENCY      = FRONT_STAGES + SQ_STAGES + DIV_STEPS + 2;

endpackage

`default_nettype wire

FILE: rtl/rmq_front.sv
// Front end: case selection, magnitudes, block normalization, sum of squares.
// Uses rmq_pkg.
`default_nettype none

module rmq_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire rmq_pkg::rmq_mat_t in_mat,
  output logic                   fr_valid,
  output logic [63:0]            fr_sum,
  output rmq_pkg::rmq_side_t     fr_side
);

  // stage 1: capture
  rmq_pkg::rmq_mat_t m_r;
  logic              v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r <= in_mat;
    end
  end

  // stage 2: trace, diagonal compares, off-diagonal sums and differences
  logic              v2_r;
  logic signed [33:0] trace2_r;
  logic              c0_2_r, c1_2_r;
  logic signed [31:0] d00_2_r, d11_2_r, d22_2_r;
  logic signed [32:0] df21_12_r, df02_20_r, df10_01_r;
  logic signed [32:0] sm01_10_r, sm02_20_r, sm12_21_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    trace2_r  <= 34'(m_r.rot_m00) + 34'(m_r.rot_m11) + 34'(m_r.rot_m22);
    c0_2_r    <= (m_r.rot_m00 > m_r.rot_m11) && (m_r.rot_m00 > m_r.rot_m22);
    c1_2_r    <= m_r.rot_m11 > m_r.rot_m22;
    d00_2_r   <= m_r.rot_m00;
    d11_2_r   <= m_r.rot_m11;
    d22_2_r   <= m_r.rot_m22;
    df21_12_r <= 33'(m_r.rot_m21) - 33'(m_r.rot_m12);
    df02_20_r <= 33'(m_r.rot_m02) - 33'(m_r.rot_m20);
    df10_01_r <= 33'(m_r.rot_m10) - 33'(m_r.rot_m01);
    sm01_10_r <= 33'(m_r.rot_m01) + 33'(m_r.rot_m10);
    sm02_20_r <= 33'(m_r.rot_m02) + 33'(m_r.rot_m20);
    sm12_21_r <= 33'(m_r.rot_m12) + 33'(m_r.rot_m21);
  end

  // stage 3: pick the case, build the undivided vector
  logic signed [34:0] one35;
  logic signed [34:0] arg3;
  logic [3:0][34:0]   vec3;
  logic               v3_r;
  logic [3:0][34:0]   vec3_r;
  logic               inv3_r;

  assign one35 = 35'(rmq_pkg::ONE_Q30);

  always_comb begin
    if (trace2_r > 34'sd0) begin
      arg3    = one35 + 35'(trace2_r);
      vec3[3] = arg3;
      vec3[0] = 35'(df21_12_r);
      vec3[1] = 35'(df02_20_r);
      vec3[2] = 35'(df10_01_r);
    end else if (c0_2_r) begin
      arg3    = one35 + 35'(d00_2_r) - 35'(d11_2_r) - 35'(d22_2_r);
      vec3[0] = arg3;
      vec3[3] = 35'(df21_12_r);
      vec3[1] = 35'(sm01_10_r);
      vec3[2] = 35'(sm02_20_r);
    end else if (c1_2_r) begin
      arg3    = one35 + 35'(d11_2_r) - 35'(d00_2_r) - 35'(d22_2_r);
      vec3[1] = arg3;
      vec3[3] = 35'(df02_20_r);
      vec3[0] = 35'(sm01_10_r);
      vec3[2] = 35'(sm12_21_r);
    end else begin
      arg3    = one35 + 35'(d22_2_r) - 35'(d00_2_r) - 35'(d11_2_r);
      vec3[2] = arg3;
      vec3[3] = 35'(df10_01_r);
      vec3[0] = 35'(sm02_20_r);
      vec3[1] = 35'(sm12_21_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    vec3_r <= vec3;
    inv3_r <= arg3 <= 35'sd0;
  end

  // stage 4: magnitudes, signs and their maximum
  logic [3:0][34:0] mag4;
  logic [34:0]      mx01, mx23;
  logic             v4_r;
  logic [3:0][34:0] mag4_r;
  logic [3:0]       neg4_r;
  logic             inv4_r;
  logic [34:0]      mx4_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag4[i] = vec3_r[i][34] ? 35'(-vec3_r[i]) : vec3_r[i];
    end
    mx01 = (mag4[0] > mag4[1]) ? mag4[0] : mag4[1];
    mx23 = (mag4[2] > mag4[3]) ? mag4[2] : mag4[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    mag4_r <= mag4;
    for (int i = 0; i < 4; i++) begin
      neg4_r[i] <= vec3_r[i][34];
    end
    inv4_r <= inv3_r;
    mx4_r  <= (mx01 > mx23) ? mx01 : mx23;
  end

  // stage 5: shift so the largest magnitude lands in [2^30, 2^31)
  logic [5:0]         msb5;
  logic [5:0]         shl5, shr5;
  rmq_pkg::rmq_side_t side5;
  logic               v5_r;
  rmq_pkg::rmq_side_t side5_r;

  always_comb begin
    msb5 = '0;
    for (int b = 0; b < 35; b++) begin
      if (mx4_r[b]) begin
        msb5 = 6'(b);
      end
    end
    shl5 = (msb5 < 6'd30) ? 6'd30 - msb5 : 6'd0;
    shr5 = (msb5 < 6'd30) ? 6'd0 : msb5 - 6'd30;
    for (int i = 0; i < 4; i++) begin
      side5.mag[i] = 31'((mag4_r[i] << shl5) >> shr5);
    end
    side5.neg     = neg4_r;
    side5.invalid = inv4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    side5_r <= side5;
  end

  // stage 6: squares
  logic               v6_r;
  logic [3:0][61:0]   sq6_r;
  rmq_pkg::rmq_side_t side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq6_r[i] <= 62'(side5_r.mag[i]) * 62'(side5_r.mag[i]);
    end
    side6_r <= side5_r;
  end

  // stage 7: sum of squares
  logic               v7_r;
  logic [63:0]        sum7_r;
  rmq_pkg::rmq_side_t side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    sum7_r  <= 64'(sq6_r[0]) + 64'(sq6_r[1]) + 64'(sq6_r[2]) + 64'(sq6_r[3]);
    side7_r <= side6_r;
  end

  assign fr_valid = v7_r;
  assign fr_sum   = sum7_r;
  assign fr_side  = side7_r;

endmodule

`default_nettype wire

FILE: rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Uses rmq_pkg.
`default_nettype none

module rmq_sqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               src_valid,
  input  wire logic [63:0]        src_num,
  input  wire rmq_pkg::rmq_side_t src_side,
  output logic                    dst_valid,
  output logic [31:0]             dst_root,
  output rmq_pkg::rmq_side_t      dst_side
);

  localparam int N = rmq_pkg::SQ_STAGES;

  logic               vld_r  [0:N];
  logic [63:0]        num_r  [0:N];
  logic [33:0]        rem_r  [0:N];
  logic [31:0]        root_r [0:N];
  rmq_pkg::rmq_side_t side_r [0:N];

  assign vld_r[0]  = src_valid;
  assign num_r[0]  = src_num;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = src_side;

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [35:0] rsh;
    logic [35:0] trial;
    logic        ge;

    // bring down the next two radicand bits, try root*4+1
    always_comb begin
      rsh   = {rem_r[g], num_r[g][63-2*g -: 2]};
      trial = {2'b00, root_r[g], 2'b01};
      ge    = rsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      num_r[g+1]  <= num_r[g];
      side_r[g+1] <= side_r[g];
      if (ge) begin
        rem_r[g+1]  <= 34'(rsh - trial);
        root_r[g+1] <= {root_r[g][30:0], 1'b1};
      end else begin
        rem_r[g+1]  <= rsh[33:0];
        root_r[g+1] <= {root_r[g][30:0], 1'b0};
      end
    end
  end

  assign dst_valid = vld_r[N];
  assign dst_root  = root_r[N];
  assign dst_side  = side_r[N];

endmodule

`default_nettype wire

FILE: rtl/rmq_div.sv
// Four-lane pipelined restoring divider with rounding and sign, plus result register.
// Uses rmq_pkg.
`default_nettype none

module rmq_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               src_valid,
  input  wire logic [31:0]        src_len,
  input  wire rmq_pkg::rmq_side_t src_side,
  output logic                    out_valid,
  output rmq_pkg::rmq_quat_t      out_quat
);

  localparam int N = rmq_pkg::DIV_STEPS;

  logic             vld_r [0:N];
  logic [31:0]      len_r [0:N];
  logic [3:0][31:0] rem_r [0:N];
  logic [3:0][30:0] low_r [0:N];
  logic [3:0][30:0] q_r   [0:N];
  logic [3:0]       neg_r [0:N];
  logic             inv_r [0:N];

  // setup: numerator = mag * 2^30 + len/2, split into start remainder and low bits
  logic [3:0][61:0] numer;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      numer[i] = 62'({src_side.mag[i], 30'b0}) + 62'(src_len[31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    len_r[0] <= src_len;
    for (int i = 0; i < 4; i++) begin
      rem_r[0][i] <= 32'(numer[i][61:31]);
      low_r[0][i] <= numer[i][30:0];
    end
    q_r[0]   <= '0;
    neg_r[0] <= src_side.neg;
    inv_r[0] <= src_side.invalid;
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [3:0][32:0] rs;
    logic [3:0]       ge;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rs[i] = {rem_r[g][i], low_r[g][i][N-1-g]};
        ge[i] = rs[i] >= {1'b0, len_r[g]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      len_r[g+1] <= len_r[g];
      low_r[g+1] <= low_r[g];
      neg_r[g+1] <= neg_r[g];
      inv_r[g+1] <= inv_r[g];
      for (int i = 0; i < 4; i++) begin
        rem_r[g+1][i] <= ge[i] ? 32'(rs[i] - {1'b0, len_r[g]}) : rs[i][31:0];
        q_r[g+1][i]   <= {q_r[g][i][29:0], ge[i]};
      end
    end
  end

  // apply signs; a non-positive root argument gives the identity
  logic [3:0][31:0]   sgn;
  rmq_pkg::rmq_quat_t quat_nxt;
  logic               out_valid_r;
  rmq_pkg::rmq_quat_t out_quat_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sgn[i] = neg_r[N][i] ? 32'(-{1'b0, q_r[N][i]}) : {1'b0, q_r[N][i]};
    end
    if (inv_r[N]) begin
      quat_nxt.quat_x  = '0;
      quat_nxt.quat_y  = '0;
      quat_nxt.quat_z  = '0;
      quat_nxt.quat_w  = rmq_pkg::ONE_Q30;
      quat_nxt.invalid = 1'b1;
    end else begin
      quat_nxt.quat_x  = sgn[0];
      quat_nxt.quat_y  = sgn[1];
      quat_nxt.quat_z  = sgn[2];
      quat_nxt.quat_w  = sgn[3];
      quat_nxt.invalid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    out_quat_r <= quat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_quat  = out_quat_r;

endmodule

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion, fully pipelined.
// Pipeline: 7 front stages, 32 square root stages, 33 divider stages.
// Throughput: one request per cycle; busy is always low and results cannot be stalled.
// Reset: synchronous, active low; clears all valid bits, in-flight requests are dropped.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div.
`default_nettype none

module rotation_matrix_to_quaternion_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rmq_pkg::rmq_mat_t in_mat,
  output logic                   out_valid,
  output rmq_pkg::rmq_quat_t     out_quat
);

  logic               fr_valid;
  logic [63:0]        fr_sum;
  rmq_pkg::rmq_side_t fr_side;
  logic               sq_valid;
  logic [31:0]        sq_root;
  rmq_pkg::rmq_side_t sq_side;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_mat   (in_mat),
    .fr_valid (fr_valid),
    .fr_sum   (fr_sum),
    .fr_side  (fr_side)
  );

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (fr_valid),
    .src_num   (fr_sum),
    .src_side  (fr_side),
    .dst_valid (sq_valid),
    .dst_root  (sq_root),
    .dst_side  (sq_side)
  );

  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (sq_valid),
    .src_len   (sq_root),
    .src_side  (sq_side),
    .out_valid (out_valid),
    .out_quat  (out_quat)
  );

endmodule

`default_nettype wire

FILE: rtl/rmq_chk.sv
// Port-level checker for the rotation matrix to quaternion core, bound to the top.
// Uses rmq_pkg and rotation_matrix_to_quaternion_core_macros.svh.
`default_nettype none
`include "rotation_matrix_to_quaternion_core_macros.svh"

module rmq_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire rmq_pkg::rmq_mat_t  in_mat,
  input wire logic               out_valid,
  input wire rmq_pkg::rmq_quat_t out_quat
);

  // strobe is sampled at the edge that ends the output register cycle
  localparam int DLY = rmq_pkg::LATENCY;

  logic in_seen;
  logic inv_is_id;
  logic in_unit;

  assign in_seen = start && (in_mat.rot_m00 == in_mat.rot_m00);

  assign inv_is_id = (out_quat.quat_x == 32'sd0) && (out_quat.quat_y == 32'sd0) &&
                     (out_quat.quat_z == 32'sd0) && (out_quat.quat_w == rmq_pkg::ONE_Q30);

  assign in_unit = (out_quat.quat_w <= rmq_pkg::ONE_Q30) &&
                   (out_quat.quat_w >= -rmq_pkg::ONE_Q30) &&
                   (out_quat.quat_x <= rmq_pkg::ONE_Q30) &&
                   (out_quat.quat_x >= -rmq_pkg::ONE_Q30);

`RMQ_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
`RMQ_ASSERT_IMPLY(a_lat_hit, in_seen, ##(DLY) out_valid, "request produced no result")
`RMQ_ASSERT_IMPLY(a_lat_idle, !start, ##(DLY) !out_valid, "result without request")
`RMQ_ASSERT_IMPLY(a_inv_identity, out_valid && out_quat.invalid, inv_is_id, "invalid not identity")
`RMQ_ASSERT_IMPLY(a_unit_range, out_valid && !out_quat.invalid, in_unit, "component beyond one")

endmodule

bind rotation_matrix_to_quaternion_core rmq_chk u_rmq_chk (.*);

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for rotation_matrix_to_quaternion_core: drives matrices, predicts
// each quaternion with a local Shepperd model and checks every result in order.
// Depends on rmq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import rmq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  rmq_mat_t  in_mat;
  logic      out_valid;
  rmq_quat_t out_quat;

  rmq_quat_t quat_expect_q[$];
  int        mismatch_cnt;
  bit        calm;
  int        sent_cnt;

  rotation_matrix_to_quaternion_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mat(in_mat), .out_valid(out_valid), .out_quat(out_quat)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic rmq_quat_t shepperd_quat(rmq_mat_t m);
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint v[4];
    longint arg, tr;
    logic [63:0] mag[4];
    bit neg[4];
    logic [63:0] mx, sum, len, q;
    rmq_quat_t r;
    m00 = m.rot_m00; m01 = m.rot_m01; m02 = m.rot_m02;
    m10 = m.rot_m10; m11 = m.rot_m11; m12 = m.rot_m12;
    m20 = m.rot_m20; m21 = m.rot_m21; m22 = m.rot_m22;
    tr = m00 + m11 + m22;
    if (tr > 0) begin
      arg = longint'(ONE_Q30) + tr;
      v[3] = arg; v[0] = m21 - m12; v[1] = m02 - m20; v[2] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      arg = longint'(ONE_Q30) + m00 - m11 - m22;
      v[0] = arg; v[3] = m21 - m12; v[1] = m01 + m10; v[2] = m02 + m20;
    end else if (m11 > m22) begin
      arg = longint'(ONE_Q30) + m11 - m00 - m22;
      v[1] = arg; v[3] = m02 - m20; v[0] = m01 + m10; v[2] = m12 + m21;
    end else begin
      arg = longint'(ONE_Q30) + m22 - m00 - m11;
      v[2] = arg; v[3] = m10 - m01; v[0] = m02 + m20; v[1] = m12 + m21;
    end
    if (arg <= 0) begin
      r = '0;
      r.quat_w = ONE_Q30;
      r.invalid = 1'b1;
      return r;
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while (mx >= 64'd1 << 31) begin
      mx = mx >> 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < 64'd1 << 30) begin
      mx = mx << 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << 30) + (len >> 1)) / len;
      if (neg[i]) q = -q;
      case (i)
        0: r.quat_x = q[31:0];
        1: r.quat_y = q[31:0];
        2: r.quat_z = q[31:0];
        default: r.quat_w = q[31:0];
      endcase
    end
    r.invalid = 1'b0;
    return r;
  endfunction

  // Predict at the accepting edge, check each strobed result.
  always @(posedge clk) begin
    rmq_quat_t exp_q;
    if (rst_n && start && !busy) quat_expect_q = {quat_expect_q, shepperd_quat(in_mat)};
    if (rst_n && out_valid) begin
      if (quat_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", out_quat);
      end else begin
        exp_q = quat_expect_q.pop_front();
        if (out_quat.quat_x !== exp_q.quat_x || out_quat.quat_y !== exp_q.quat_y ||
            out_quat.quat_z !== exp_q.quat_z || out_quat.quat_w !== exp_q.quat_w ||
            out_quat.invalid !== exp_q.invalid) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected x=%h y=%h z=%h w=%h inv=%b",
                     exp_q.quat_x, exp_q.quat_y, exp_q.quat_z, exp_q.quat_w, exp_q.invalid);
            $display("          got      x=%h y=%h z=%h w=%h inv=%b",
                     out_quat.quat_x, out_quat.quat_y, out_quat.quat_z, out_quat.quat_w,
                     out_quat.invalid);
          end
        end
      end
    end
  end

  // Send one request; random gaps unless in a calm stretch.
  task automatic send_mat(rmq_mat_t m);
    while (!calm && $urandom_range(99, 0) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_mat <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic idle_sender();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(5, 0))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return ONE_Q30;
      3: return -ONE_Q30;
      4: return $signed($urandom_range(32'h4000_0000, 0)) - 32'sh2000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Rotation from a random angle about a random main axis, with small noise.
  function automatic rmq_mat_t rand_rotation();
    rmq_mat_t m;
    real a, c, s;
    int ax;
    logic signed [31:0] cq, sq;
    a = ($urandom_range(62831, 0) / 10000.0) - 3.14159;
    c = $cos(a); s = $sin(a);
    cq = $rtoi(c * 1073741824.0) + $signed($urandom_range(64, 0)) - 32;
    sq = $rtoi(s * 1073741824.0) + $signed($urandom_range(64, 0)) - 32;
    ax = $urandom_range(2, 0);
    m = '0;
    m.rot_m00 = ONE_Q30; m.rot_m11 = ONE_Q30; m.rot_m22 = ONE_Q30;
    case (ax)
      0: begin m.rot_m11 = cq; m.rot_m12 = -sq; m.rot_m21 = sq; m.rot_m22 = cq; end
      1: begin m.rot_m00 = cq; m.rot_m02 = sq; m.rot_m20 = -sq; m.rot_m22 = cq; end
      default: begin m.rot_m00 = cq; m.rot_m01 = -sq; m.rot_m10 = sq; m.rot_m11 = cq; end
    endcase
    // mirror signs to reach the diagonal cases
    if ($urandom_range(1, 0)) begin
      m.rot_m00 = -m.rot_m00; m.rot_m01 = -m.rot_m01; m.rot_m02 = -m.rot_m02;
      m.rot_m10 = -m.rot_m10; m.rot_m11 = -m.rot_m11; m.rot_m12 = -m.rot_m12;
    end
    return m;
  endfunction

  task automatic test_directed();
    rmq_mat_t m;
    m = '0; m.rot_m00 = ONE_Q30; m.rot_m11 = ONE_Q30; m.rot_m22 = ONE_Q30;
    send_mat(m);                                    // identity, trace case
    m = '0; m.rot_m00 = ONE_Q30; m.rot_m11 = -ONE_Q30; m.rot_m22 = -ONE_Q30;
    send_mat(m);                                    // x dominant
    m = '0; m.rot_m00 = -ONE_Q30; m.rot_m11 = ONE_Q30; m.rot_m22 = -ONE_Q30;
    send_mat(m);                                    // y dominant
    m = '0; m.rot_m00 = -ONE_Q30; m.rot_m11 = -ONE_Q30; m.rot_m22 = ONE_Q30;
    send_mat(m);                                    // z dominant
    m = '0; m.rot_m00 = -ONE_Q30; m.rot_m11 = -ONE_Q30; m.rot_m22 = -ONE_Q30;
    send_mat(m);                                    // ties, falls to the z case
    m = '0;
    send_mat(m);                                    // zero matrix, trace zero
    m = '0; m.rot_m00 = ONE_Q30; m.rot_m11 = ONE_Q30;
    send_mat(m);                                    // tie between m00 and m11, trace case
    send_mat('1);                                   // all minus one lsb
    m = {9{32'sh8000_0000}};
    send_mat(m);
    m = {9{32'sh7fff_ffff}};
    send_mat(m);
    m = '0; m.rot_m00 = 32'sh7fff_ffff; m.rot_m11 = 32'sh8000_0000;
    m.rot_m22 = 32'sh8000_0000;
    send_mat(m);                                    // largest x argument
    m = {32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
         32'sh0000_0001, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000};
    send_mat(m);
    m = '0; m.rot_m00 = -ONE_Q30; m.rot_m11 = 32'sh0000_0001; m.rot_m22 = -ONE_Q30;
    send_mat(m);                                    // y dominant, argument 3*ONE_Q30 + 1
    for (int i = 0; i < 6; i++) send_mat(rand_rotation());
  endtask

  task automatic test_random(int n);
    rmq_mat_t m;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 3 + 150);
      if ($urandom_range(99, 0) < 70) begin
        m = rand_rotation();
      end else begin
        for (int k = 0; k < 9; k++) m[k*32 +: 32] = rand_elem();
      end
      send_mat(m);
    end
    calm = 0;
  endtask

  // Hold requests until the pipeline has drained.
  task automatic test_drain_pause();
    idle_sender();
    while (quat_expect_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mat = '0;
    mismatch_cnt = 0;
    calm = 0;
    sent_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(600);
    test_drain_pause();
    test_random(630);
    idle_sender();
    while (quat_expect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_cnt == 0 && quat_expect_q.size() == 0)
      $display("rotation_matrix_to_quaternion_core verification clean");
    else
      $display("rotation_matrix_to_quaternion_core verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rotation_matrix_to_quaternion_core verification failed");
    $finish;
  end

endmodule
